>>> hdl/wtsc_pkg.sv
// Package: shared codes, command and status types, and calendar helper functions.
package wtsc_pkg;

    // Action codes carried by an input word.
    localparam logic [1:0] ACT_REFRESH = 2'd0;
    localparam logic [1:0] ACT_SHORT   = 2'd1;
    localparam logic [1:0] ACT_LONG    = 2'd2;

    // Key codes.
    localparam logic [1:0] KEY_SAVE = 2'd0;
    localparam logic [1:0] KEY_NEXT = 2'd1;
    localparam logic [1:0] KEY_DOWN = 2'd2;
    localparam logic [1:0] KEY_UP   = 2'd3;

    // Mode codes.
    localparam logic [2:0] MODE_RUN    = 3'd0;
    localparam logic [2:0] MODE_HOUR   = 3'd1;
    localparam logic [2:0] MODE_MINUTE = 3'd2;
    localparam logic [2:0] MODE_SECOND = 3'd3;
    localparam logic [2:0] MODE_YEAR   = 3'd4;
    localparam logic [2:0] MODE_MONTH  = 3'd5;
    localparam logic [2:0] MODE_DAY    = 3'd6;

    // Divisors used by the constant divider.
    localparam logic [16:0] DIV_DAY  = 17'd86400;
    localparam logic [16:0] DIV_HOUR = 17'd3600;
    localparam logic [16:0] DIV_MIN  = 17'd60;
    localparam logic [16:0] DIV_WEEK = 17'd7;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_TOGGLE,
        OP_MODE_HOUR,
        OP_MODE_NEXT,
        OP_MODE_PREV,
        OP_FIELDS,
        OP_DAYS,
        OP_SECS,
        OP_SAVE,
        OP_LOAD_COUNT,
        OP_LOAD_T,
        OP_TAKE_DAYS,
        OP_TAKE_HOUR,
        OP_TAKE_MIN,
        OP_TAKE_WD,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_DAY_SET
    } dp_op_t;

    // Which division the constant divider performs.
    typedef enum logic [1:0] {
        DSEL_DAYS,
        DSEL_HOUR,
        DSEL_MIN,
        DSEL_WEEK
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_start;
        div_sel_t div_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] key;
        logic       editing;
        logic       div_busy;
        logic       t_bad;
        logic       year_more;
        logic       month_more;
    } dp_stat_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic        display_on;
        logic        counter_write;
        logic [31:0] counter_value;
    } res_t;

    // Days before the start of a March-based month index (0 is March).
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Length of a calendar month, 1 to 12.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/wtsc_in_if.sv
// Interface: input channel carrying one key or refresh word.
interface wtsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  key;
    logic [31:0] rtc_count;

    modport source (output valid, output action, output key, output rtc_count, input ready);
    modport sink (input valid, input action, input key, input rtc_count, output ready);
endinterface

>>> hdl/wtsc_out_if.sv
// Interface: output channel carrying one result word.
interface wtsc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        display_on;
    logic        counter_write;
    logic [31:0] counter_value;

    modport source (output valid, output mode, output year, output month, output day,
                    output hour, output minute, output second, output weekday,
                    output display_on, output counter_write, output counter_value,
                    input ready);
    modport sink (input valid, input mode, input year, input month, input day,
                  input hour, input minute, input second, input weekday,
                  input display_on, input counter_write, input counter_value,
                  output ready);
endinterface

>>> hdl/wtsc_div.sv
// Constant divider: reciprocal product, then quotient, then remainder, registered.
module wtsc_div
    import wtsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  div_sel_t    sel,
    output logic        busy,
    output logic [31:0] quo,
    output logic [16:0] rem
);

    logic        busy_reg;
    logic [1:0]  step_reg;
    div_sel_t    sel_reg;
    logic [31:0] num_reg;
    logic [50:0] prod_reg;
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] prod_calc;
    logic [31:0] quo_calc;
    logic [16:0] dvs;
    logic [32:0] back_mul;
    logic [31:0] rem_calc;

    // The low zero bits of each divisor are shifted out first, which keeps every
    // reciprocal exact over the operand range it sees.
    always_comb
    begin
        case (sel_reg)
            DSEL_DAYS:
            begin
                mul_a    = num_reg[31:7];
                mul_b    = 26'd50903317;
                quo_calc = {16'd0, prod_reg[50:35]};
                dvs      = DIV_DAY;
            end
            DSEL_HOUR:
            begin
                mul_a    = {12'd0, num_reg[16:4]};
                mul_b    = 26'd9321;
                quo_calc = {27'd0, prod_reg[25:21]};
                dvs      = DIV_HOUR;
            end
            DSEL_MIN:
            begin
                mul_a    = {15'd0, num_reg[11:2]};
                mul_b    = 26'd1093;
                quo_calc = {26'd0, prod_reg[19:14]};
                dvs      = DIV_MIN;
            end
            default:
            begin
                mul_a    = {9'd0, num_reg[15:0]};
                mul_b    = 26'd74899;
                quo_calc = {19'd0, prod_reg[31:19]};
                dvs      = DIV_WEEK;
            end
        endcase
    end

    // Reciprocal product, then the remainder from the quotient.
    assign prod_calc = {26'd0, mul_a} * {25'd0, mul_b};
    assign back_mul  = {17'd0, quo_reg[15:0]} * {16'd0, dvs};
    assign rem_calc  = num_reg - back_mul[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            sel_reg <= sel;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:    prod_reg <= prod_calc;
                2'd1:    quo_reg <= quo_calc;
                default: rem_reg <= rem_calc[16:0];
            endcase
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/wtsc_dp.sv
// Datapath: mode, calendar fields, edit arithmetic, conversion loops and result register.
module wtsc_dp
    import wtsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [1:0]  in_action,
    input  logic [1:0]  in_key,
    input  logic [31:0] in_count,
    output dp_stat_t    stat,
    output res_t        res
);

    // Architectural state.
    logic [2:0]  mode_reg;
    logic [7:0]  cal_year_reg;
    logic [3:0]  cal_month_reg;
    logic [4:0]  cal_day_reg;
    logic [4:0]  cal_hour_reg;
    logic [5:0]  cal_minute_reg;
    logic [5:0]  cal_second_reg;
    logic [2:0]  cal_weekday_reg;
    logic        screen_reg;

    // Working registers.
    logic [1:0]  act_reg;
    logic [1:0]  key_reg;
    logic [31:0] count_reg;
    logic        wr_reg;
    logic [31:0] wval_reg;
    logic signed [12:0] yy_reg;
    logic [3:0]  mp_reg;
    logic signed [6:0]  ed_d_reg;
    logic signed [6:0]  ed_h_reg;
    logic signed [7:0]  ed_mi_reg;
    logic signed [7:0]  ed_s_reg;
    logic signed [19:0] ed_days_reg;
    logic signed [39:0] t_reg;
    logic [31:0] secs_reg;
    logic [15:0] days_reg;
    logic [16:0] rem_reg;
    logic [11:0] rem2_reg;
    logic [15:0] dl_reg;
    res_t        res_reg;

    // Next values of the edit stages.
    logic signed [12:0] yy_next;
    logic [3:0]  mp_next;
    logic signed [6:0]  ed_d_next;
    logic signed [6:0]  ed_h_next;
    logic signed [7:0]  ed_mi_next;
    logic signed [7:0]  ed_s_next;
    logic signed [19:0] ed_days_next;
    logic signed [39:0] t_next;

    // Divider connections.
    logic        div_busy;
    logic [31:0] div_quo;
    logic [16:0] div_rem;
    logic [31:0] div_dividend;

    // Calendar helpers for the year and month loops.
    logic [11:0] year_full;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        editing;

    assign editing   = (mode_reg >= MODE_HOUR) && (mode_reg <= MODE_DAY);
    assign year_full = 12'd1970 + {4'd0, cal_year_reg};
    assign leap      = (year_full[1:0] == 2'd0) && (year_full != 12'd2100);
    assign ylen      = leap ? 9'd366 : 9'd365;
    assign mlen      = month_days(cal_month_reg, leap);

    // Divider operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            DSEL_DAYS: div_dividend = secs_reg;
            DSEL_HOUR: div_dividend = {15'd0, rem_reg};
            DSEL_MIN:  div_dividend = {20'd0, rem2_reg};
            default:   div_dividend = {16'd0, days_reg} + 32'd4;
        endcase
    end

    wtsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .sel      (cmd.div_sel),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // Edit stage one: apply the step to one field and fold the month into the year.
    always_comb
    begin
        int y;
        int mo;
        int d;
        int h;
        int mi;
        int s;
        int dlt;
        int m;
        y   = 1970 + int'(cal_year_reg);
        mo  = int'(cal_month_reg);
        d   = int'(cal_day_reg);
        h   = int'(cal_hour_reg);
        mi  = int'(cal_minute_reg);
        s   = int'(cal_second_reg);
        dlt = (key_reg == KEY_UP) ? 1 : ((key_reg == KEY_DOWN) ? -1 : 0);
        case (mode_reg)
            MODE_HOUR:   h  = h + dlt;
            MODE_MINUTE: mi = mi + dlt;
            MODE_SECOND: s  = s + dlt;
            MODE_YEAR:   y  = y + dlt;
            MODE_MONTH:  mo = mo + dlt;
            MODE_DAY:    d  = d + dlt;
            default:     y  = y;
        endcase
        if (mo < 1)
        begin
            mo = mo + 12;
            y  = y - 1;
        end
        else if (mo > 12)
        begin
            mo = mo - 12;
            y  = y + 1;
        end
        m = mo;
        if (m <= 2)
        begin
            y = y - 1;
        end
        yy_next    = 13'(y);
        mp_next    = (m > 2) ? 4'(m - 3) : 4'(m + 9);
        ed_d_next  = 7'(d);
        ed_h_next  = 7'(h);
        ed_mi_next = 8'(mi);
        ed_s_next  = 8'(s);
    end

    // Edit stage two: days since the epoch from the shifted year and month.
    always_comb
    begin
        int yy;
        int yoe;
        int c100;
        int doy;
        int doe;
        int base;
        yy   = int'(yy_reg);
        base = (yy >= 2000) ? 730485 : 584388;
        yoe  = (yy >= 2000) ? (yy - 2000) : (yy - 1600);
        c100 = (yoe >= 300) ? 3 : ((yoe >= 200) ? 2 : ((yoe >= 100) ? 1 : 0));
        doy  = int'(month_start(mp_reg)) + int'(ed_d_reg) - 1;
        doe  = yoe * 365 + (yoe >>> 2) - c100 + doy;
        ed_days_next = 20'(base + doe - 719468);
    end

    // Edit stage three: seconds since the epoch.
    always_comb
    begin
        longint tt;
        tt = longint'(ed_days_reg) * 86400 + longint'(ed_h_reg) * 3600
           + longint'(ed_mi_reg) * 60 + longint'(ed_s_reg);
        t_next = 40'(tt);
    end

    // Control state of the calendar.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RUN;
            cal_year_reg    <= 8'd0;
            cal_month_reg   <= 4'd1;
            cal_day_reg     <= 5'd1;
            cal_hour_reg    <= 5'd0;
            cal_minute_reg  <= 6'd0;
            cal_second_reg  <= 6'd0;
            cal_weekday_reg <= 3'd4;
            screen_reg      <= 1'b1;
        end
        else
        begin
            case (cmd.op)
                OP_TOGGLE:    screen_reg <= ~screen_reg;
                OP_MODE_HOUR: mode_reg <= MODE_HOUR;
                OP_MODE_NEXT: mode_reg <= (mode_reg == MODE_DAY) ? MODE_RUN : 3'(mode_reg + 3'd1);
                OP_MODE_PREV: mode_reg <= 3'(mode_reg - 3'd1);
                OP_SAVE:      mode_reg <= MODE_RUN;
                OP_TAKE_DAYS:
                begin
                    cal_year_reg  <= 8'd0;
                    cal_month_reg <= 4'd1;
                end
                OP_TAKE_HOUR: cal_hour_reg <= div_quo[4:0];
                OP_TAKE_MIN:
                begin
                    cal_minute_reg <= div_quo[5:0];
                    cal_second_reg <= div_rem[5:0];
                end
                OP_TAKE_WD:    cal_weekday_reg <= div_rem[2:0];
                OP_YEAR_STEP:  cal_year_reg <= cal_year_reg + 8'd1;
                OP_MONTH_STEP: cal_month_reg <= cal_month_reg + 4'd1;
                OP_DAY_SET:    cal_day_reg <= 5'(dl_reg[4:0] + 5'd1);
                default:       mode_reg <= mode_reg;
            endcase
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                act_reg   <= in_action;
                key_reg   <= in_key;
                count_reg <= in_count;
                wr_reg    <= 1'b0;
                wval_reg  <= '0;
            end
            OP_FIELDS:
            begin
                yy_reg    <= yy_next;
                mp_reg    <= mp_next;
                ed_d_reg  <= ed_d_next;
                ed_h_reg  <= ed_h_next;
                ed_mi_reg <= ed_mi_next;
                ed_s_reg  <= ed_s_next;
            end
            OP_DAYS:       ed_days_reg <= ed_days_next;
            OP_SECS:       t_reg <= t_next;
            OP_SAVE:
            begin
                wr_reg   <= 1'b1;
                wval_reg <= t_reg[31:0];
            end
            OP_LOAD_COUNT: secs_reg <= count_reg;
            OP_LOAD_T:     secs_reg <= t_reg[31:0];
            OP_TAKE_DAYS:
            begin
                days_reg <= div_quo[15:0];
                dl_reg   <= div_quo[15:0];
                rem_reg  <= div_rem;
            end
            OP_TAKE_HOUR:  rem2_reg <= div_rem[11:0];
            OP_YEAR_STEP:  dl_reg <= dl_reg - {7'd0, ylen};
            OP_MONTH_STEP: dl_reg <= dl_reg - {11'd0, mlen};
            default:       dl_reg <= dl_reg;
        endcase
        if (cmd.out_load)
        begin
            res_reg.mode          <= mode_reg;
            res_reg.year          <= year_full;
            res_reg.month         <= cal_month_reg;
            res_reg.day           <= cal_day_reg;
            res_reg.hour          <= cal_hour_reg;
            res_reg.minute        <= cal_minute_reg;
            res_reg.second        <= cal_second_reg;
            res_reg.weekday       <= cal_weekday_reg;
            res_reg.display_on    <= screen_reg;
            res_reg.counter_write <= wr_reg;
            res_reg.counter_value <= wval_reg;
        end
    end

    // Status back to the controller.
    assign stat.action     = act_reg;
    assign stat.key        = key_reg;
    assign stat.editing    = editing;
    assign stat.div_busy   = div_busy;
    assign stat.t_bad      = t_reg[39:32] != 8'd0;
    assign stat.year_more  = dl_reg >= {7'd0, ylen};
    assign stat.month_more = dl_reg >= {11'd0, mlen};
    assign res             = res_reg;

endmodule

>>> hdl/wtsc_ctrl.sv
// Controller: sequences decoding, edit arithmetic, divisions, calendar loops and output.
module wtsc_ctrl
    import wtsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_ready,
    output logic     out_valid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DAYS_CALC,
        ST_SECS_CALC,
        ST_CHECK,
        ST_DAYS_GO,
        ST_DAYS_WAIT,
        ST_HOUR_GO,
        ST_HOUR_WAIT,
        ST_MIN_GO,
        ST_MIN_WAIT,
        ST_WD_GO,
        ST_WD_WAIT,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and datapath command.
    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DSEL_DAYS;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                case (stat.action)
                    ACT_REFRESH:
                    begin
                        if (!stat.editing)
                        begin
                            cmd.op     = OP_LOAD_COUNT;
                            state_next = ST_DAYS_GO;
                        end
                    end
                    ACT_SHORT:
                    begin
                        if (!stat.editing)
                        begin
                            if (stat.key == KEY_SAVE)
                            begin
                                cmd.op = OP_TOGGLE;
                            end
                            else if (stat.key == KEY_NEXT)
                            begin
                                cmd.op = OP_MODE_HOUR;
                            end
                        end
                        else if (stat.key == KEY_NEXT)
                        begin
                            cmd.op = OP_MODE_NEXT;
                        end
                        else
                        begin
                            cmd.op     = OP_FIELDS;
                            state_next = ST_DAYS_CALC;
                        end
                    end
                    ACT_LONG:
                    begin
                        if (stat.editing && stat.key == KEY_NEXT)
                        begin
                            cmd.op = OP_MODE_PREV;
                        end
                    end
                    default:
                    begin
                        cmd.op = OP_NONE;
                    end
                endcase
            end
            ST_DAYS_CALC:
            begin
                cmd.op     = OP_DAYS;
                state_next = ST_SECS_CALC;
            end
            ST_SECS_CALC:
            begin
                cmd.op     = OP_SECS;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.key == KEY_SAVE)
                begin
                    cmd.op     = OP_SAVE;
                    state_next = ST_DONE;
                end
                else if (stat.t_bad)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_LOAD_T;
                    state_next = ST_DAYS_GO;
                end
            end
            ST_DAYS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_DAYS;
                state_next    = ST_DAYS_WAIT;
            end
            ST_DAYS_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = OP_TAKE_DAYS;
                    state_next = ST_HOUR_GO;
                end
            end
            ST_HOUR_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_HOUR;
                state_next    = ST_HOUR_WAIT;
            end
            ST_HOUR_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = OP_TAKE_HOUR;
                    state_next = ST_MIN_GO;
                end
            end
            ST_MIN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_MIN;
                state_next    = ST_MIN_WAIT;
            end
            ST_MIN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = OP_TAKE_MIN;
                    state_next = ST_WD_GO;
                end
            end
            ST_WD_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_WEEK;
                state_next    = ST_WD_WAIT;
            end
            ST_WD_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = OP_TAKE_WD;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (stat.year_more)
                begin
                    cmd.op = OP_YEAR_STEP;
                end
                else
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (stat.month_more)
                begin
                    cmd.op = OP_MONTH_STEP;
                end
                else
                begin
                    cmd.op     = OP_DAY_SET;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result register is free once its word is taken.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/watch_time_set_controller.sv
// Top level of the watch time-setting controller.
//
//   Channel   Direction   Contents
//   item      in          action, key, rtc_count
//   result    out         mode, calendar fields, weekday, display_on, counter write
//
// A word that only changes mode or display goes from decoding straight to the result stage.
// A save, or an edit dropped as out of range, passes the days, seconds and range-check states.
// A refresh or a kept edit runs four constant divisions, then steps once per year since 1970
// and once per month into the year.
// One word is worked at a time; the next is taken while the last result waits.
// Reset gives run mode, 1970-01-01 00:00:00, Thursday, display on.
module watch_time_set_controller
    import wtsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    wtsc_in_if.sink     item,
    wtsc_out_if.source  result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    res_t     res;

    wtsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    wtsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_action (item.action),
        .in_key    (item.key),
        .in_count  (item.rtc_count),
        .stat      (stat),
        .res       (res)
    );

    // Result word onto the output channel.
    assign result.mode          = res.mode;
    assign result.year          = res.year;
    assign result.month         = res.month;
    assign result.day           = res.day;
    assign result.hour          = res.hour;
    assign result.minute        = res.minute;
    assign result.second        = res.second;
    assign result.weekday       = res.weekday;
    assign result.display_on    = res.display_on;
    assign result.counter_write = res.counter_write;
    assign result.counter_value = res.counter_value;

endmodule

>>> hdl/wtsc_checker.sv
// Checker: port-level assertions on the watch time-setting controller, with its bind.
module wtsc_checker
    import wtsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  mode,
    input logic        counter_write,
    input logic [31:0] counter_value
);

    // A result word waits until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped before it was taken");

    // A saved time always comes with run mode.
    a_save_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && counter_write |-> mode == MODE_RUN)
        else $error("save reported outside run mode");

    // No counter value without a save.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !counter_write |-> counter_value == 32'd0)
        else $error("counter value without a save");

    // One word is worked at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in work");

    // Mode code seven never shows.
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mode != 3'd7)
        else $error("invalid mode on result");

endmodule

bind watch_time_set_controller wtsc_checker u_wtsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .mode          (result.mode),
    .counter_write (result.counter_write),
    .counter_value (result.counter_value)
);
